>>> hdl/kmd_pkg.sv
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int ROWS      = 8;
  localparam int COLS      = 8;
  localparam int KEY_COUNT = ROWS * COLS;
  localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam int RAW_W  = 64;
  localparam int CNT_W  = 4;
  localparam int POS_W  = 3;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;

  // register select is paddr[3]: threshold at 0x0, mask at 0x8
  localparam logic REG_THR  = 1'b0;
  localparam logic REG_MASK = 1'b1;

  localparam logic [CNT_W-1:0] THR_RST = 4'd3;

  // one state entry per key
  typedef struct packed {
    logic             prev;
    logic [CNT_W-1:0] cnt;
    logic             deb;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [CNT_W-1:0] thr;
    logic [RAW_W-1:0] mask;
  } cfg_t;

endpackage

>>> hdl/kmd_if.sv
`timescale 1ns / 1ps

interface kmd_in_if;
  import kmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink (input valid, input raw_keys, output ready);
endinterface

interface kmd_out_if;
  import kmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] key_row;
  logic [POS_W-1:0] key_col;
  logic             pressed;
  logic             last;

  modport source (output valid, output key_row, output key_col, output pressed,
                  output last, input ready);
  modport sink (input valid, input key_row, input key_col, input pressed,
                input last, output ready);
endinterface

>>> hdl/kmd_ram.sv
`timescale 1ns / 1ps

module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kmd_cfg.sv
`timescale 1ns / 1ps

module kmd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kmd_pkg::CFG_AW-1:0] paddr,
  input  logic [kmd_pkg::CFG_DW-1:0] pwdata,
  output logic [kmd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output kmd_pkg::cfg_t              cfg
);
  import kmd_pkg::*;

  logic [CNT_W-1:0] thr_r;
  logic [RAW_W-1:0] mask_r;
  logic             wr;
  logic             sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RST;
      mask_r <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_THR:  thr_r  <= pwdata[CNT_W-1:0];
        REG_MASK: mask_r <= pwdata[RAW_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_THR:  prdata = {{(CFG_DW-CNT_W){1'b0}}, thr_r};
      REG_MASK: prdata = mask_r;
    endcase
  end

  assign cfg.thr  = thr_r;
  assign cfg.mask = mask_r;

endmodule

>>> hdl/kmd_scan.sv
`timescale 1ns / 1ps

module kmd_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kmd_pkg::cfg_t             cfg,
  kmd_in_if.sink                    in_chan,
  kmd_out_if.source                 out_chan,
  output logic                      ram_re,
  output logic [kmd_pkg::KEY_W-1:0] ram_raddr,
  input  logic [kmd_pkg::ENT_W-1:0] ram_rdata,
  output logic                      ram_we,
  output logic [kmd_pkg::KEY_W-1:0] ram_waddr,
  output logic [kmd_pkg::ENT_W-1:0] ram_wdata
);
  import kmd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT, ST_FLUSH} st_t;

  st_t                  st_r;
  logic [KEY_COUNT-1:0] raw_r;
  logic [KEY_W-1:0]     key_r;
  logic [POS_W-1:0]     row_r;
  logic [POS_W-1:0]     col_r;
  logic                 s2_v_r;
  logic [KEY_W-1:0]     s2_key_r;
  logic [POS_W-1:0]     s2_row_r;
  logic [POS_W-1:0]     s2_col_r;
  logic                 vq_r;
  logic [KEY_COUNT-1:0] vld_r;
  logic                 pend_v_r;
  logic [POS_W-1:0]     pend_row_r;
  logic [POS_W-1:0]     pend_col_r;
  logic                 pend_prs_r;
  logic                 out_v_r;
  logic [POS_W-1:0]     out_row_r;
  logic [POS_W-1:0]     out_col_r;
  logic                 out_prs_r;
  logic                 out_last_r;

  logic [KEY_COUNT-1:0] key_mask;
  ent_t                 cur;
  ent_t                 ent_nxt;
  logic                 bit_in;
  logic                 flip;
  logic                 evt;
  logic                 out_free;
  logic                 s2_go;
  logic                 adv;
  logic                 issue;
  logic                 flush_go;
  logic                 last_key;
  logic                 out_load;

  assign key_mask = cfg.mask[KEY_COUNT-1:0];
  // never-written entries read as released with a clear counter
  assign cur      = vq_r ? ent_t'(ram_rdata) : '0;
  assign bit_in   = raw_r[s2_key_r];

  always_comb begin
    ent_nxt = cur;
    if (bit_in == cur.prev) begin
      if (cur.cnt < cfg.thr) begin
        ent_nxt.cnt = cur.cnt + CNT_W'(1);
      end
    end else begin
      ent_nxt.cnt  = '0;
      ent_nxt.prev = bit_in;
    end
    flip = (ent_nxt.cnt >= cfg.thr) && (bit_in != cur.deb);
    if (flip) begin
      ent_nxt.deb = bit_in;
    end
  end

  assign evt      = flip & ~key_mask[s2_key_r];
  assign out_free = ~out_v_r | out_chan.ready;
  assign s2_go    = s2_v_r & (~(evt & pend_v_r) | out_free);
  assign adv      = ~s2_v_r | s2_go;
  assign issue    = (st_r == ST_SCAN) & adv;
  assign flush_go = (st_r == ST_FLUSH) & (~pend_v_r | out_free);
  assign last_key = (row_r == POS_W'(ROWS - 1)) && (col_r == POS_W'(COLS - 1));
  assign out_load = (s2_go & evt & pend_v_r) | (flush_go & pend_v_r);

  assign ram_re    = issue;
  assign ram_raddr = key_r;
  assign ram_we    = s2_go;
  assign ram_waddr = s2_key_r;
  assign ram_wdata = ent_nxt;

  assign in_chan.ready    = (st_r == ST_IDLE);
  assign out_chan.valid   = out_v_r;
  assign out_chan.key_row = out_row_r;
  assign out_chan.key_col = out_col_r;
  assign out_chan.pressed = out_prs_r;
  assign out_chan.last    = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      s2_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      vld_r    <= '0;
    end else begin
      if (s2_go) begin
        vld_r[s2_key_r] <= 1'b1;
      end
      if (issue) begin
        vq_r     <= vld_r[key_r];
        s2_key_r <= key_r;
        s2_row_r <= row_r;
        s2_col_r <= col_r;
      end
      if (adv) begin
        s2_v_r <= issue;
      end

      // hold one event back so the final one of a frame can carry last
      if (s2_go && evt) begin
        pend_v_r   <= 1'b1;
        pend_row_r <= s2_row_r;
        pend_col_r <= s2_col_r;
        pend_prs_r <= bit_in;
      end else if (flush_go) begin
        pend_v_r <= 1'b0;
      end

      if (out_load) begin
        out_v_r    <= 1'b1;
        out_row_r  <= pend_row_r;
        out_col_r  <= pend_col_r;
        out_prs_r  <= pend_prs_r;
        out_last_r <= flush_go;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end

      unique case (st_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            raw_r <= in_chan.raw_keys[KEY_COUNT-1:0];
            key_r <= '0;
            row_r <= '0;
            col_r <= '0;
            st_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            key_r <= key_r + KEY_W'(1);
            if (col_r == POS_W'(COLS - 1)) begin
              col_r <= '0;
              row_r <= row_r + POS_W'(1);
            end else begin
              col_r <= col_r + POS_W'(1);
            end
            if (last_key) begin
              st_r <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (s2_go) begin
            st_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_go) begin
            st_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> hdl/key_matrix_debouncer.sv
`timescale 1ns / 1ps

// Key matrix debouncer. Each accepted word on in_chan is one raw scan frame
// (bit row*COLS+col set = key pressed); the block walks the keys in row-major
// order and emits a press/release word on out_chan for every key whose
// debounced state flips and whose silent_key_mask bit is clear, with last set
// on the final word of the frame. Per-key state (last raw bit, saturating
// agreement counter, debounced bit) lives in one single-port-write RAM with a
// registered read, updated read-modify-write at one key per cycle unless
// out_chan back-pressures; in_chan.ready returns after the last key's update
// and the flush of the held-back event. Entries are marked valid as they are
// written, so the state reads as cleared right after reset with no clearing
// pass. Registers: debounce_samples at 0x0 (4 bits, reset 3) and
// silent_key_mask at 0x8 (64 bits, reset 0); write them only while idle.
module key_matrix_debouncer (
  input  logic                       clk,
  input  logic                       rst_n,
  kmd_in_if.sink                     in_chan,
  kmd_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kmd_pkg::CFG_AW-1:0] paddr,
  input  logic [kmd_pkg::CFG_DW-1:0] pwdata,
  output logic [kmd_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import kmd_pkg::*;

  cfg_t             cfg;
  logic             ram_re;
  logic [KEY_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  logic             ram_we;
  logic [KEY_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;

  // register file: threshold and silent mask
  kmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-key state store
  kmd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (KEY_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // key sequencer, debounce update and event output
  kmd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

endmodule

>>> tb/key_matrix_debouncer_checker.sv
`timescale 1ns / 1ps

module key_matrix_debouncer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  kmd_in_if                          in_mon,
  kmd_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kmd_pkg::CFG_AW-1:0] paddr,
  input  logic [kmd_pkg::CFG_DW-1:0] pwdata,
  input  logic [kmd_pkg::CFG_DW-1:0] prdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         events_pending,
  output int                         frames_seen,
  output int                         events_seen
);
  import kmd_pkg::*;

  // registers sit on an 8-byte stride, so this address bit picks one
  localparam int SEL_BIT = 3;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             pressed;
    logic             last;
  } key_event_t;

  key_event_t       expected_events [$];
  logic             raw_seen  [KEY_COUNT];
  logic [CNT_W-1:0] agree_cnt [KEY_COUNT];
  logic             key_down  [KEY_COUNT];
  logic [CNT_W-1:0] threshold;
  logic [RAW_W-1:0] silent_mask;
  int               errors;
  int               frames;
  int               events;

  function automatic void check_field(input string name, input logic [CFG_DW-1:0] want,
                                      input logic [CFG_DW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // walk the keys row-major, update per-key state, queue the press/release words
  task automatic debounce_frame(input logic [RAW_W-1:0] raw);
    key_event_t ev;
    int         k;
    int         first;
    logic       sample;
    first = expected_events.size();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        k = r * COLS + c;
        sample = raw[k];
        if (sample == raw_seen[k]) begin
          if (agree_cnt[k] < threshold) agree_cnt[k] = agree_cnt[k] + CNT_W'(1);
        end else begin
          agree_cnt[k] = '0;
          raw_seen[k] = sample;
        end
        if (agree_cnt[k] >= threshold && sample != key_down[k]) begin
          key_down[k] = sample;
          if (!silent_mask[k]) begin
            ev.row     = POS_W'(r);
            ev.col     = POS_W'(c);
            ev.pressed = sample;
            ev.last    = 1'b0;
            expected_events.push_back(ev);
          end
        end
      end
    end
    if (expected_events.size() > first) begin
      ev = expected_events.pop_back();
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    if (!rst_n) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        raw_seen[k]  = 1'b0;
        agree_cnt[k] = '0;
        key_down[k]  = 1'b0;
      end
      threshold   = THR_RST;
      silent_mask = '0;
      expected_events.delete();
      errors = 0;
      frames = 0;
      events = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        debounce_frame(in_mon.raw_keys);
        frames++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.key_row, out_mon.key_col, out_mon.pressed, out_mon.last};
        if (expected_events.size() == 0) begin
          errors++;
          $display({"%0t: unexpected event word, expected none, ",
                    "actual row %0d col %0d pressed %0d last %0d"},
                   $time, got.row, got.col, got.pressed, got.last);
        end else begin
          want = expected_events.pop_front();
          check_field("key_row", CFG_DW'(want.row), CFG_DW'(got.row));
          check_field("key_col", CFG_DW'(want.col), CFG_DW'(got.col));
          check_field("pressed", CFG_DW'(want.pressed), CFG_DW'(got.pressed));
          check_field("last", CFG_DW'(want.last), CFG_DW'(got.last));
        end
        events++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[SEL_BIT] == REG_MASK) silent_mask = pwdata;
          else threshold = pwdata[CNT_W-1:0];
        end else if (paddr[SEL_BIT] == REG_MASK) begin
          check_field("silent_key_mask readback", silent_mask, prdata);
        end else begin
          check_field("debounce_samples readback", CFG_DW'(threshold), prdata);
        end
      end
    end
    fail_count     <= errors;
    events_pending <= expected_events.size();
    frames_seen    <= frames;
    events_seen    <= events;
  end

endmodule

>>> tb/key_matrix_debouncer_tb.sv
`timescale 1ns / 1ps

module key_matrix_debouncer_tb;
  import kmd_pkg::*;

  localparam int HALF_PERIOD   = 6;
  // a frame walks every key once plus a short pipeline tail
  localparam int FRAME_LATENCY = KEY_COUNT + 8;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SEG_ITEMS     = 55;
  localparam int SEGMENTS      = 9;

  localparam logic [CFG_AW-1:0] THR_ADDR  = {REG_THR, 3'b000};
  localparam logic [CFG_AW-1:0] MASK_ADDR = {REG_MASK, 3'b000};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  kmd_in_if  in_if ();
  kmd_out_if out_if ();

  int               send_idle_pct = 15;
  int               recv_idle_pct = 58;
  bit               stall_request = 1'b0;
  int               quiet_cycles  = 0;
  int               reg_writes    = 0;
  int               fail_count;
  int               events_pending;
  int               frames_seen;
  int               events_seen;
  logic [RAW_W-1:0] cur_target    = '0;

  // per-segment thresholds: both extremes, a few small ones in between
  logic [CNT_W-1:0] seg_thr [SEGMENTS] = '{4'd0, 4'd15, 4'd2, 4'd1, 4'd4,
                                           4'd0, 4'd3, 4'd15, 4'd6};

  always #(HALF_PERIOD) clk = ~clk;

  key_matrix_debouncer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  key_matrix_debouncer_checker event_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .frames_seen    (frames_seen),
    .events_seen    (events_seen)
  );

  // Receiver: drop ready at random, or hold it low for a long stretch on
  // request so the block backs up and stalls its input.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_request = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [RAW_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Write a register, then read it back so the checker can compare prdata.
  // Open with an edge so back-to-back calls never touch psel twice in a step.
  task automatic program_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  // Offer one scan frame and hold it until the block takes the word. A random
  // gap before the offer lands anywhere inside the block's key walk.
  task automatic send_frame(input logic [RAW_W-1:0] raw);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 80) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.raw_keys <= raw;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Pause the sender until every predicted event has come out, then let a
  // frame's worth of cycles pass in case the last frame produced nothing.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (FRAME_LATENCY) @(posedge clk);
  endtask

  task automatic load_config(input logic [CNT_W-1:0] thr, input logic [RAW_W-1:0] mask);
    logic [CFG_DW-1:0] junk;
    junk = rand_word();
    // upper bits of the threshold word are don't-care; toggle them anyway
    program_reg(THR_ADDR, {junk[CFG_DW-1:CNT_W], thr});
    program_reg(MASK_ADDR, mask);
  endtask

  // Mostly well-formed key changes: pick a new target pattern, bounce around
  // it for a few frames, then hold it long enough to pass the threshold.
  // Some runs are cut short and some frames are pure noise.
  task automatic run_segment(input logic [CNT_W-1:0] thr, input logic [RAW_W-1:0] mask,
                             input bit hold);
    int sent;
    int stable;
    sent = 0;
    wait_idle();
    load_config(thr, mask);
    if (hold) stall_request = 1'b1;
    while (sent < SEG_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        send_frame(rand_word());
        sent++;
      end else begin
        case ($urandom_range(3))
          0: cur_target = rand_word();
          1: cur_target = cur_target ^ (64'd1 << $urandom_range(63));
          2: cur_target = cur_target ^ (rand_word() & rand_word() & rand_word());
          default: cur_target = ~cur_target;
        endcase
        repeat ($urandom_range(0, 3)) begin
          send_frame(cur_target ^ (rand_word() & rand_word() & rand_word()));
          sent++;
        end
        stable = int'(thr) + 1 + $urandom_range(0, 2);
        if ($urandom_range(4) == 0) stable = $urandom_range(0, thr);
        repeat (stable) begin
          send_frame(cur_target);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [RAW_W-1:0] mask;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_if.valid    <= 1'b0;
    in_if.raw_keys <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values first: threshold 3, nothing masked. Full press, full
    // release, a checkerboard too short to settle, then one frame of noise.
    repeat (4) send_frame('1);
    repeat (4) send_frame('0);
    repeat (3) send_frame({32{2'b10}});
    send_frame({32{2'b01}});

    // Zero threshold: every change is taken in the frame it shows up;
    // half the keys silenced.
    wait_idle();
    load_config(4'd0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_frame(64'h0123_4567_89AB_CDEF);
    send_frame(~64'h0123_4567_89AB_CDEF);
    send_frame('0);

    // Maximum threshold with every key silent: counters climb, no words.
    wait_idle();
    load_config(4'd15, '1);
    repeat (5) send_frame('1);

    // Lower the threshold under the running counters: all keys flip at once.
    wait_idle();
    load_config(4'd2, '0);
    send_frame('1);
    send_frame('0);

    // Random part: idling mix per third, long receiver stalls at two points.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 58;
      end else if (seg < 6) begin
        send_idle_pct = 58;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 2) mask = '1;
      else if (seg == 8) mask = rand_word() & rand_word();
      else if (seg % 2 == 1) mask = rand_word();
      else mask = '0;
      run_segment(seg_thr[seg], mask, (seg == 0) || (seg == 6));
    end

    wait_idle();
    $display("Covered %0d scan frames and %0d key event words over %0d register writes,",
             frames_seen, events_seen, reg_writes);
    $display("thresholds 0 through 15, silenced keys, long output stalls, three idling mixes.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/kmd_pkg.sv
hdl/kmd_if.sv
hdl/kmd_ram.sv
hdl/kmd_cfg.sv
hdl/kmd_scan.sv
hdl/key_matrix_debouncer.sv
tb/key_matrix_debouncer_checker.sv
tb/key_matrix_debouncer_tb.sv
